@@ design/ptc_pkg.sv @@
// shared types, constants and helpers for the pressure and temperature compensation block
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int RAW_W   = 20;
  localparam int TEMP_W  = 20;
  localparam int FINE_W  = 25;
  localparam int PRESS_W = 32;
  localparam int CFG_W   = 64;
  localparam int ADDR_W  = 6;

  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] RAW_FULL    = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [27:0] ROUND_HALF  = 28'd128;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coef_t;

  // one front-to-back queue entry
  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic [FINE_W-1:0] fine;
    logic [63:0]       numer;
    logic [63:0]       denom;
  } job_t;

  typedef enum logic [2:0] {
    REG_T1,
    REG_T2,
    REG_T3,
    REG_P1,
    REG_P25,
    REG_P69
  } reg_idx_t;

  typedef enum logic [3:0] {
    FOP_TA,
    FOP_TB,
    FOP_TC,
    FOP_SQ,
    FOP_P6,
    FOP_P5,
    FOP_P3,
    FOP_P2,
    FOP_P1,
    FOP_SCALE
  } front_op_t;

  typedef enum logic [1:0] {
    BOP_P9A,
    BOP_P9B,
    BOP_P8
  } back_op_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_ISSUE,
    FS_WAIT,
    FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_DIV,
    BS_SIGN,
    BS_ISSUE,
    BS_WAIT,
    BS_OUT
  } back_state_t;

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

endpackage

@@ design/pressure_temp_compensation_top.sv @@
// Trimmed temperature and pressure compensation, 64-bit pressure path.
// Input channel: in_valid/in_ready carries one beat of raw_temperature and
// raw_pressure (20 bits each). Output channel: out_valid/out_ready carries
// temperature_centi, fine_temperature, pressure_q24_8 and pressure_invalid,
// exactly one output beat per input beat, in order.
// Trims are written over the APB port at 8-byte spacing (t1, t2, t3, p1,
// p2..p5, p6..p9); write them only while no beat is in flight.
// The front part runs ten multiplies on its own sequential multiplier; the
// back part runs a one-bit-a-step divider plus three multiplies on a
// second one. A two-entry queue sits between them, so the front part can
// prepare later beats while the back part still works on an earlier one.
// A zero divisor skips the divide and the multiplies; its beat goes to the
// output register with pressure 0 and pressure_invalid set.
// Reset clears all trims to zero and empties the pipeline.
// When the receiver stalls, the result waits in the output register, the
// back part finishes its next job, the queue fills and then in_ready drops.
`timescale 1ns / 1ps

module pressure_temp_compensation_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptc_pkg::ADDR_W-1:0]   paddr,
  input  logic [ptc_pkg::CFG_W-1:0]    pwdata,
  output logic [ptc_pkg::CFG_W-1:0]    prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ptc_pkg::RAW_W-1:0]    raw_temperature,
  input  logic [ptc_pkg::RAW_W-1:0]    raw_pressure,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ptc_pkg::TEMP_W-1:0]   temperature_centi,
  output logic [ptc_pkg::FINE_W-1:0]   fine_temperature,
  output logic [ptc_pkg::PRESS_W-1:0]  pressure_q24_8,
  output logic                         pressure_invalid
);
  import ptc_pkg::*;

  logic [15:0] temp_t1;
  logic [15:0] temp_t2;
  logic [15:0] temp_t3;
  logic [15:0] press_p1;
  logic [63:0] press_p2_to_p5;
  logic [63:0] press_p6_to_p9;
  reg_idx_t    idx;
  logic        wr_en;
  coef_t       coef;
  logic        q_wr_valid;
  logic        q_wr_ready;
  job_t        q_wr_data;
  logic        q_rd_valid;
  logic        q_rd_ready;
  job_t        q_rd_data;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_t1        <= '0;
      temp_t2        <= '0;
      temp_t3        <= '0;
      press_p1       <= '0;
      press_p2_to_p5 <= '0;
      press_p6_to_p9 <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_T1:  temp_t1        <= pwdata[15:0];
        REG_T2:  temp_t2        <= pwdata[15:0];
        REG_T3:  temp_t3        <= pwdata[15:0];
        REG_P1:  press_p1       <= pwdata[15:0];
        REG_P25: press_p2_to_p5 <= pwdata;
        REG_P69: press_p6_to_p9 <= pwdata;
        default: press_p1       <= press_p1;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_T1:  prdata = {48'b0, temp_t1};
      REG_T2:  prdata = {48'b0, temp_t2};
      REG_T3:  prdata = {48'b0, temp_t3};
      REG_P1:  prdata = {48'b0, press_p1};
      REG_P25: prdata = press_p2_to_p5;
      REG_P69: prdata = press_p6_to_p9;
      default: prdata = '0;
    endcase
  end

  always_comb begin
    coef.t1 = temp_t1;
    coef.t2 = temp_t2;
    coef.t3 = temp_t3;
    coef.p1 = press_p1;
    coef.p2 = press_p2_to_p5[15:0];
    coef.p3 = press_p2_to_p5[31:16];
    coef.p4 = press_p2_to_p5[47:32];
    coef.p5 = press_p2_to_p5[63:48];
    coef.p6 = press_p6_to_p9[15:0];
    coef.p7 = press_p6_to_p9[31:16];
    coef.p8 = press_p6_to_p9[47:32];
    coef.p9 = press_p6_to_p9[63:48];
  end

  ptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .coef            (coef),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .push_valid      (q_wr_valid),
    .push_ready      (q_wr_ready),
    .push_data       (q_wr_data)
  );

  ptc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  ptc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .coef              (coef),
    .pop_valid         (q_rd_valid),
    .pop_ready         (q_rd_ready),
    .pop_data          (q_rd_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_centi (temperature_centi),
    .fine_temperature  (fine_temperature),
    .pressure_q24_8    (pressure_q24_8),
    .pressure_invalid  (pressure_invalid)
  );

endmodule

@@ design/ptc_mul64.sv @@
// sequential 64 x 64 multiplier giving the low 64 bits, one 32 x 32 partial product a cycle
`timescale 1ns / 1ps

module ptc_mul64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a_in,
  input  logic [63:0] b_in,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] pp;
  logic [63:0] acc;
  logic [1:0]  phase;
  logic        busy;
  logic [31:0] op_a;
  logic [31:0] op_b;

  // lo*lo, then the two cross terms; hi*hi never reaches the low 64 bits
  always_comb begin
    case (phase)
      2'd0: begin
        op_a = a[31:0];
        op_b = b[31:0];
      end
      2'd1: begin
        op_a = a[31:0];
        op_b = b[63:32];
      end
      2'd2: begin
        op_a = a[63:32];
        op_b = b[31:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= a_in;
      b   <= b_in;
      acc <= '0;
    end else if (busy) begin
      pp <= {32'b0, op_a} * {32'b0, op_b};
      case (phase)
        2'd1: acc <= pp;
        2'd2: acc <= acc + {pp[31:0], 32'b0};
        2'd3: acc <= acc + {pp[31:0], 32'b0};
        default: acc <= acc;
      endcase
    end
  end

  assign prod = acc;

endmodule

@@ design/ptc_fifo.sv @@
// short queue of prepared jobs between the front and back parts
`timescale 1ns / 1ps

module ptc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ptc_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output ptc_pkg::job_t rd_data
);
  import ptc_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ design/ptc_front.sv @@
// front part: takes raw readings, runs the temperature stage and prepares the pressure divide
`timescale 1ns / 1ps

module ptc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  ptc_pkg::coef_t             coef,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_temperature,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_pressure,
  output logic                       push_valid,
  input  logic                       push_ready,
  output ptc_pkg::job_t              push_data
);
  import ptc_pkg::*;

  front_state_t      state;
  front_state_t      state_next;
  front_op_t         op;
  logic              buf_valid;
  logic [RAW_W-1:0]  buf_t;
  logic [RAW_W-1:0]  buf_p;
  logic [RAW_W-1:0]  adc_t;
  logic [RAW_W-1:0]  adc_p;
  logic              take;
  logic              accept;
  logic              mul_start;
  logic              mul_done;
  logic [63:0]       mul_a;
  logic [63:0]       mul_b;
  logic [63:0]       prod;
  logic [63:0]       tv1;
  logic [63:0]       bb;
  logic [FINE_W-1:0] fine;
  logic [63:0]       sq;
  logic [63:0]       v2;
  logic [63:0]       w;
  logic [63:0]       denom;
  logic [63:0]       numer;
  logic [63:0]       ta;
  logic [63:0]       tb;
  logic [63:0]       fsum;
  logic [63:0]       pv1;
  logic [63:0]       num0;
  logic [27:0]       t5;

  assign accept   = in_valid && in_ready;
  assign in_ready = !buf_valid;

  // one-entry input buffer so a new beat lands while the sequencer works
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (accept) begin
      buf_valid <= 1'b1;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_t <= raw_temperature;
      buf_p <= raw_pressure;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE:  if (buf_valid) state_next = FS_ISSUE;
      FS_ISSUE: state_next = FS_WAIT;
      FS_WAIT: begin
        if (mul_done) state_next = (op == FOP_SCALE) ? FS_PUSH : FS_ISSUE;
      end
      FS_PUSH:  if (push_ready) state_next = FS_IDLE;
      default:  state_next = FS_IDLE;
    endcase
  end

  always_comb begin
    take       = (state == FS_IDLE) && buf_valid;
    mul_start  = (state == FS_ISSUE);
    push_valid = (state == FS_PUSH);
  end

  assign ta   = {47'b0, adc_t[19:3]} - {47'b0, coef.t1, 1'b0};
  assign tb   = {48'b0, adc_t[19:4]} - {48'b0, coef.t1};
  assign fsum = tv1 + asr64(prod, 14);
  assign pv1  = {{39{fine[FINE_W-1]}}, fine} - FINE_OFFSET;
  assign num0 = ((RAW_FULL - {44'b0, adc_p}) << 31) - v2;
  // fine * 5 + 128, then floor shift by 8
  assign t5   = {{3{fine[FINE_W-1]}}, fine} + {fine[FINE_W-1], fine, 2'b0} + ROUND_HALF;

  always_comb begin
    case (op)
      FOP_TA: begin
        mul_a = ta;
        mul_b = sext16(coef.t2);
      end
      FOP_TB: begin
        mul_a = tb;
        mul_b = tb;
      end
      FOP_TC: begin
        mul_a = asr64(bb, 12);
        mul_b = sext16(coef.t3);
      end
      FOP_SQ: begin
        mul_a = pv1;
        mul_b = pv1;
      end
      FOP_P6: begin
        mul_a = sq;
        mul_b = sext16(coef.p6);
      end
      FOP_P5: begin
        mul_a = pv1;
        mul_b = sext16(coef.p5);
      end
      FOP_P3: begin
        mul_a = sq;
        mul_b = sext16(coef.p3);
      end
      FOP_P2: begin
        mul_a = pv1;
        mul_b = sext16(coef.p2);
      end
      FOP_P1: begin
        mul_a = (64'd1 << 47) + w;
        mul_b = {48'b0, coef.p1};
      end
      FOP_SCALE: begin
        mul_a = num0;
        mul_b = PRESS_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      adc_t <= buf_t;
      adc_p <= buf_p;
      op    <= FOP_TA;
    end else if (state == FS_WAIT && mul_done) begin
      if (op != FOP_SCALE) begin
        op <= front_op_t'(op + 4'd1);
      end
      case (op)
        FOP_TA:    tv1   <= asr64(prod, 11);
        FOP_TB:    bb    <= prod;
        FOP_TC:    fine  <= fsum[FINE_W-1:0];
        FOP_SQ:    sq    <= prod;
        FOP_P6:    v2    <= prod + (sext16(coef.p4) << 35);
        FOP_P5:    v2    <= v2 + (prod << 17);
        FOP_P3:    w     <= asr64(prod, 8);
        FOP_P2:    w     <= w + (prod << 12);
        FOP_P1:    denom <= asr64(prod, 33);
        FOP_SCALE: numer <= prod;
        default:   numer <= numer;
      endcase
    end
  end

  ptc_mul64 u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign push_data.temperature = t5[27:8];
  assign push_data.fine        = fine;
  assign push_data.numer       = numer;
  assign push_data.denom       = denom;

endmodule

@@ design/ptc_back.sv @@
// back part: signed 64-bit divide, final pressure polynomial and the output register
`timescale 1ns / 1ps

module ptc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  ptc_pkg::coef_t              coef,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  ptc_pkg::job_t               pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ptc_pkg::TEMP_W-1:0]  temperature_centi,
  output logic [ptc_pkg::FINE_W-1:0]  fine_temperature,
  output logic [ptc_pkg::PRESS_W-1:0] pressure_q24_8,
  output logic                        pressure_invalid
);
  import ptc_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  back_op_t          op;
  logic [TEMP_W-1:0] temp;
  logic [FINE_W-1:0] fine;
  logic              invalid;
  logic              neg;
  logic [63:0]       quo;
  logic [63:0]       rem;
  logic [63:0]       mb;
  logic [5:0]        cnt;
  logic [63:0]       pval;
  logic [63:0]       x;
  logic [63:0]       v1;
  logic [63:0]       sum;
  logic [64:0]       rem_sh;
  logic [64:0]       diff;
  logic              pop;
  logic              load;
  logic              mul_start;
  logic              mul_done;
  logic [63:0]       mul_a;
  logic [63:0]       mul_b;
  logic [63:0]       prod;
  logic [63:0]       na_mag;
  logic [63:0]       nb_mag;
  logic [31:0]       press;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE: begin
        if (pop_valid) state_next = (pop_data.denom == '0) ? BS_OUT : BS_DIV;
      end
      BS_DIV:   if (cnt == 6'd63) state_next = BS_SIGN;
      BS_SIGN:  state_next = BS_ISSUE;
      BS_ISSUE: state_next = BS_WAIT;
      BS_WAIT: begin
        if (mul_done) state_next = (op == BOP_P8) ? BS_OUT : BS_ISSUE;
      end
      BS_OUT:   if (!out_valid || out_ready) state_next = BS_IDLE;
      default:  state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state == BS_IDLE);
    pop       = (state == BS_IDLE) && pop_valid;
    mul_start = (state == BS_ISSUE);
    load      = (state == BS_OUT) && (!out_valid || out_ready);
  end

  // magnitudes for a truncating divide
  assign na_mag = pop_data.numer[63] ? (64'd0 - pop_data.numer) : pop_data.numer;
  assign nb_mag = pop_data.denom[63] ? (64'd0 - pop_data.denom) : pop_data.denom;
  assign rem_sh = {rem, quo[63]};
  assign diff   = rem_sh - {1'b0, mb};

  always_comb begin
    case (op)
      BOP_P9A: begin
        mul_a = sext16(coef.p9);
        mul_b = asr64(pval, 13);
      end
      BOP_P9B: begin
        mul_a = x;
        mul_b = asr64(pval, 13);
      end
      BOP_P8: begin
        mul_a = sext16(coef.p8);
        mul_b = pval;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      temp    <= pop_data.temperature;
      fine    <= pop_data.fine;
      invalid <= (pop_data.denom == '0);
      neg     <= pop_data.numer[63] ^ pop_data.denom[63];
      quo     <= na_mag;
      mb      <= nb_mag;
      rem     <= '0;
      cnt     <= '0;
    end else if (state == BS_DIV) begin
      cnt <= cnt + 6'd1;
      if (!diff[64]) begin
        rem <= diff[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end else if (state == BS_SIGN) begin
      pval <= neg ? (64'd0 - quo) : quo;
      op   <= BOP_P9A;
    end else if (state == BS_WAIT && mul_done) begin
      if (op != BOP_P8) begin
        op <= back_op_t'(op + 2'd1);
      end
      case (op)
        BOP_P9A: x   <= prod;
        BOP_P9B: v1  <= asr64(prod, 25);
        BOP_P8:  sum <= pval + v1 + asr64(prod, 19);
        default: sum <= sum;
      endcase
    end
  end

  ptc_mul64 u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign press = sum[39:8] + {{12{coef.p7[15]}}, coef.p7, 4'b0};

  // output register decouples the receiver from the next job
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      temperature_centi <= temp;
      fine_temperature  <= fine;
      pressure_q24_8    <= invalid ? '0 : press;
      pressure_invalid  <= invalid;
    end
  end

endmodule
